FILE: src/bit_unpack_frame_of_reference_core_macros.svh
// assertion helpers, clocked on clk_i and held off while rst_ni is low
`ifndef BIT_UNPACK_FRAME_OF_REFERENCE_CORE_MACROS_SVH
`define BIT_UNPACK_FRAME_OF_REFERENCE_CORE_MACROS_SVH

// consequent checked in the same cycle
`define BUFOR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define BUFOR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bufor_pkg.sv
`timescale 1ns / 1ps

package bufor_pkg;

  localparam int unsigned MaxWidth = 64;
  localparam int unsigned CntW     = $clog2(MaxWidth + 1);
  localparam int unsigned ValueW   = 64;
  localparam int unsigned IndexW   = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned VwFieldW = 7;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  typedef logic [CntW-1:0] width_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgValueWidth  = 3'd0,
    CfgOutSize     = 3'd1,
    CfgBaseOffset  = 3'd2,
    CfgValueCount  = 3'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OutSize8  = 2'd0,
    OutSize16 = 2'd1,
    OutSize32 = 2'd2,
    OutSize64 = 2'd3
  } out_size_e;

  typedef struct packed {
    logic [ByteW-1:0] packed_byte;
    logic             first_byte;
  } item_t;

  typedef struct packed {
    width_t            width;
    out_size_e         out_size;
    logic [ValueW-1:0] base_offset;
    logic [IndexW-1:0] value_count;
  } cfg_t;

  typedef struct packed {
    logic [MaxWidth-1:0] raw;
    logic [IndexW-1:0]   value_index;
    logic                last_in_byte;
    logic                last_value;
  } result_t;

  // zero reads as one, anything above the maximum as the maximum
  function automatic width_t eff_width(logic [VwFieldW-1:0] vw);
    width_t w;
    if (vw == '0) begin
      w = width_t'(1);
    end else if (vw > VwFieldW'(MaxWidth)) begin
      w = width_t'(MaxWidth);
    end else begin
      w = width_t'(vw);
    end
    return w;
  endfunction

  function automatic logic [MaxWidth-1:0] low_mask(width_t w);
    return ~({MaxWidth{1'b1}} << w);
  endfunction

  function automatic logic [ValueW-1:0] out_mask(out_size_e s);
    logic [ValueW-1:0] m;
    unique case (s)
      OutSize8:  m = ValueW'(64'h0000_0000_0000_00FF);
      OutSize16: m = ValueW'(64'h0000_0000_0000_FFFF);
      OutSize32: m = ValueW'(64'h0000_0000_FFFF_FFFF);
      default:   m = ValueW'(64'hFFFF_FFFF_FFFF_FFFF);
    endcase
    return m;
  endfunction

endpackage

FILE: src/bufor_if.sv
`timescale 1ns / 1ps

interface bufor_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       first_byte;

  modport source (output valid, output packed_byte, output first_byte, input ready);
  modport sink   (input valid, input packed_byte, input first_byte, output ready);
endinterface

interface bufor_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [31:0] value_index;
  logic        last_in_byte;
  logic        last_value;

  modport source (output valid, output value, output value_index, output last_in_byte,
                  output last_value, input ready);
  modport sink   (input valid, input value, input value_index, input last_in_byte,
                  input last_value, output ready);
endinterface

FILE: src/bufor_front.sv
`timescale 1ns / 1ps

module bufor_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bufor_in_if.sink             in_i,
  output logic                 head_valid_o,
  output bufor_pkg::item_t     head_o,
  input  logic                 pop_i
);

  bufor_pkg::item_t                 mem_q [bufor_pkg::QDepth];
  logic [bufor_pkg::QPtrW-1:0]      wr_q, rd_q;
  logic [bufor_pkg::QCntW-1:0]      cnt_q;
  logic                             push, pop;
  bufor_pkg::item_t                 in_item;

  assign in_i.ready   = (cnt_q != bufor_pkg::QCntW'(bufor_pkg::QDepth));
  assign push         = in_i.valid && in_i.ready;
  assign head_valid_o = (cnt_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = mem_q[rd_q];

  assign in_item.packed_byte = in_i.packed_byte;
  assign in_item.first_byte  = in_i.first_byte;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == bufor_pkg::QPtrW'(bufor_pkg::QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == bufor_pkg::QPtrW'(bufor_pkg::QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + bufor_pkg::QCntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - bufor_pkg::QCntW'(1);
      end
    end
  end

endmodule

FILE: src/bufor_back.sv
`timescale 1ns / 1ps

module bufor_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bufor_pkg::cfg_t   cfg_i,
  input  logic              head_valid_i,
  input  bufor_pkg::item_t  head_i,
  output logic              pop_o,
  bufor_out_if.source       out_o
);

  localparam int unsigned MaxW = bufor_pkg::MaxWidth;
  localparam int unsigned ValW = bufor_pkg::ValueW;
  localparam int unsigned IdxW = bufor_pkg::IndexW;

  // gather state
  logic [2:0]                 pos_q, pos_d;
  bufor_pkg::width_t          pcnt_q, pcnt_d;
  logic [MaxW-1:0]            pbits_q, pbits_d;
  logic [IdxW-1:0]            ecnt_q, ecnt_d;

  // result stage and output register
  logic                       s1_valid_q, s1_valid_d;
  bufor_pkg::result_t         s1_q, s1_d;
  logic                       out_valid_q;
  logic [ValW-1:0]            value_q;
  logic [IdxW-1:0]            index_q;
  logic                       lib_q, lv_q;

  logic                       out_adv, s1_adv, fresh, done0, stale, fits, emit;
  logic                       done_after, last_in, s1_last;
  bufor_pkg::width_t          pc, need;
  logic [MaxW-1:0]            pb, ins, absorb_ins;
  logic [IdxW-1:0]            ec, ec_inc;
  logic [3:0]                 rem, consumed, remaining;
  logic [7:0]                 sbyte, field;

  always_comb begin
    out_adv    = !out_valid_q || out_o.ready;
    s1_adv     = !s1_valid_q || out_adv;
    fresh      = head_i.first_byte && (pos_q == '0);
    pc         = fresh ? '0 : pcnt_q;
    pb         = fresh ? '0 : pbits_q;
    ec         = fresh ? '0 : ecnt_q;
    rem        = 4'd8 - {1'b0, pos_q};
    sbyte      = head_i.packed_byte >> pos_q;
    done0      = (ec >= cfg_i.value_count);
    stale      = (pc >= cfg_i.width);
    need       = cfg_i.width - pc;
    fits       = (need <= bufor_pkg::width_t'(rem));
    consumed   = stale ? 4'd1 : need[3:0];
    field      = sbyte & ~(8'hFF << need);
    ins        = MaxW'(field) << pc;
    absorb_ins = MaxW'(sbyte) << pc;
    ec_inc     = ec + IdxW'(1);
    remaining  = rem - consumed;
    done_after = (ec_inc >= cfg_i.value_count);
    last_in    = done_after || (bufor_pkg::width_t'(remaining) < cfg_i.width);
    emit       = head_valid_i && s1_adv && !done0 && (stale || fits);

    pos_d      = pos_q;
    pcnt_d     = pcnt_q;
    pbits_d    = pbits_q;
    ecnt_d     = ecnt_q;
    pop_o      = 1'b0;
    s1_valid_d = s1_adv ? 1'b0 : s1_valid_q;
    s1_d       = s1_q;

    if (head_valid_i && s1_adv) begin
      priority if (done0) begin
        // batch already complete: the byte is dropped with any stored bits
        pop_o   = 1'b1;
        pos_d   = '0;
        pcnt_d  = '0;
        pbits_d = '0;
        ecnt_d  = ec;
      end else if (stale || fits) begin
        s1_valid_d        = 1'b1;
        s1_d.raw          = (stale ? pb : (pb | ins)) & bufor_pkg::low_mask(cfg_i.width);
        s1_d.value_index  = ec;
        s1_d.last_in_byte = last_in;
        s1_d.last_value   = (ec_inc == cfg_i.value_count);
        ecnt_d            = ec_inc;
        pcnt_d            = '0;
        pbits_d           = '0;
        if (done_after || remaining == '0) begin
          pop_o = 1'b1;
          pos_d = '0;
        end else begin
          pos_d = pos_q + consumed[2:0];
        end
      end else begin
        // remaining bits of the byte do not complete a value
        pbits_d = pb | absorb_ins;
        pcnt_d  = pc + bufor_pkg::width_t'(rem);
        ecnt_d  = ec;
        pop_o   = 1'b1;
        pos_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      pcnt_q      <= '0;
      pbits_q     <= '0;
      ecnt_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      pcnt_q     <= pcnt_d;
      pbits_q    <= pbits_d;
      ecnt_q     <= ecnt_d;
      s1_valid_q <= s1_valid_d;
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    if (out_adv && s1_valid_q) begin
      value_q <= (ValW'(s1_q.raw) + cfg_i.base_offset) & bufor_pkg::out_mask(cfg_i.out_size);
      index_q <= s1_q.value_index;
      lib_q   <= s1_q.last_in_byte;
      lv_q    <= s1_q.last_value;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.value        = value_q;
  assign out_o.value_index  = index_q;
  assign out_o.last_in_byte = lib_q;
  assign out_o.last_value   = lv_q;

  assign s1_last = s1_valid_q && s1_q.last_value;

  `include "bit_unpack_frame_of_reference_core_macros.svh"

  `BUFOR_ASSERT_NEXT(a_emit_clears_pending, emit, pcnt_q == '0, "stored bits kept after a value")
  `BUFOR_ASSERT_SAME(a_last_value_ends_byte, s1_last, s1_q.last_in_byte, "batch end not byte end")
  `BUFOR_ASSERT_NEXT(a_pop_rewinds, pop_o, pos_q == '0, "bit position not rewound on pop")

endmodule

FILE: src/bit_unpack_frame_of_reference_core.sv
`timescale 1ns / 1ps

// frame-of-reference bit unpacker
// in_i carries one byte of a packed stream per transfer, bit 0 first, plus a
// first_byte flag that starts a new batch (stored bits and value count cleared).
// out_o carries one unpacked value per transfer: the low value_width bits,
// plus base_offset, wrapped to the configured output size, with its index in
// the batch and flags for the last value of the byte and of the batch.
// configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i); write
// it only while no transfer is in flight. unknown indexes are ignored.
// throughput: the gather stage makes one value per cycle while the output side
// accepts it; a byte stays at the queue head while it yields its values and then,
// if bits are left over after its last value, while they are stored; a byte that
// completes nothing, or lands after the batch is complete, is popped with no value.
// an accepted byte is written into the queue, the gather stage registers the raw
// value, and the base add lands in the output register behind out_o.valid.
// a two-entry input queue keeps in_i flowing while the output is stalled; a
// stalled out_o holds its value and backs up the gather stage, then the queue.
// reset clears the queue, stored bits, counts and loads the default registers
// (width 8, 64-bit output, base 0, count 0).

module bit_unpack_frame_of_reference_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  bufor_in_if.sink                            in_i,
  bufor_out_if.source                         out_o,
  input  logic                                cfg_we_i,
  input  logic [bufor_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [bufor_pkg::CfgDataW-1:0]      cfg_data_i
);

  // configuration registers
  logic [bufor_pkg::VwFieldW-1:0] value_width_q;
  bufor_pkg::out_size_e           out_size_q;
  logic [bufor_pkg::ValueW-1:0]   base_offset_q;
  logic [bufor_pkg::IndexW-1:0]   value_count_q;
  bufor_pkg::cfg_t                cfg;

  // queue head towards the gather stage
  logic                           head_valid;
  bufor_pkg::item_t               head;
  logic                           pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_width_q <= bufor_pkg::VwFieldW'(8);
      out_size_q    <= bufor_pkg::OutSize64;
      base_offset_q <= '0;
      value_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (bufor_pkg::cfg_idx_e'(cfg_idx_i))
        bufor_pkg::CfgValueWidth: value_width_q <= cfg_data_i[bufor_pkg::VwFieldW-1:0];
        bufor_pkg::CfgOutSize:    out_size_q    <= bufor_pkg::out_size_e'(cfg_data_i[1:0]);
        bufor_pkg::CfgBaseOffset: base_offset_q <= cfg_data_i[bufor_pkg::ValueW-1:0];
        bufor_pkg::CfgValueCount: value_count_q <= cfg_data_i[bufor_pkg::IndexW-1:0];
        default: ;
      endcase
    end
  end

  // width clamped once here so the gather stage sees 1 .. MaxWidth
  assign cfg.width       = bufor_pkg::eff_width(value_width_q);
  assign cfg.out_size    = out_size_q;
  assign cfg.base_offset = base_offset_q;
  assign cfg.value_count = value_count_q;

  bufor_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  bufor_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule
